### hw/rtl/assert_macros.svh
// Assertion helpers for RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/gfa_pkg.sv
package gfa_pkg;

    // Data widths
    localparam int WORD_W = 32;
    localparam int PROD_W = 2 * WORD_W - 1;
    localparam int CNT_W  = $clog2(WORD_W);
    localparam int NUM_FIELDS = 3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [WORD_W:0]   t_poly;
    typedef logic [1:0]        t_sel;
    typedef logic [2:0]        t_op;
    typedef logic [1:0]        t_msel;
    typedef logic [2:0]        t_asel;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Operation codes
    localparam t_op OP_ADD = 3'd0;
    localparam t_op OP_SUB = 3'd1;
    localparam t_op OP_MUL = 3'd2;
    localparam t_op OP_DIV = 3'd3;
    localparam t_op OP_INV = 3'd4;
    localparam t_op OP_NEG = 3'd5;

    // Field selector codes
    localparam t_sel SEL_GF8  = 2'd0;
    localparam t_sel SEL_GF16 = 2'd1;
    localparam t_sel SEL_GF32 = 2'd2;

    // Field polynomials, bit i is the coefficient of x^i
    localparam t_poly POLY_GF8  = 33'h0_0000_011D;
    localparam t_poly POLY_GF16 = 33'h0_0001_03DD;
    localparam t_poly POLY_GF32 = 33'h1_0040_0007;

    // Multiplier operand selection
    localparam t_msel MUL_AB = 2'd0;
    localparam t_msel MUL_SQ = 2'd1;
    localparam t_msel MUL_AX = 2'd2;
    localparam t_msel MUL_BX = 2'd3;

    // Accumulator load selection
    localparam t_asel ACC_HOLD = 3'd0;
    localparam t_asel ACC_MUL  = 3'd1;
    localparam t_asel ACC_XOR  = 3'd2;
    localparam t_asel ACC_A    = 3'd3;
    localparam t_asel ACC_ZERO = 3'd4;
    localparam t_asel ACC_ONE  = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic  capture;
        t_asel acc_sel;
        t_msel mul_sel;
        logic  err_load;
        logic  err_val;
        logic  out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic a_zero;
        logic b_zero;
        t_cnt m_minus1;
        t_sel sel;
    } t_stat;

    // Reduction table: x^k mod p for every product bit k, one row per field
    typedef t_word [PROD_W-1:0]    t_red_row;
    typedef t_red_row [NUM_FIELDS-1:0] t_red_tab;

    // Treat the unused selector code as the widest field
    function automatic t_sel sat_sel(t_sel s);
        return (s == SEL_GF8 || s == SEL_GF16) ? s : SEL_GF32;
    endfunction

    function automatic t_word field_mask(t_sel s);
        t_word m;
        unique case (sat_sel(s))
            SEL_GF8:  m = t_word'(8'hFF);
            SEL_GF16: m = t_word'(16'hFFFF);
            default:  m = '1;
        endcase
        return m;
    endfunction

    function automatic t_cnt field_m1(t_sel s);
        t_cnt c;
        unique case (sat_sel(s))
            SEL_GF8:  c = t_cnt'(7);
            SEL_GF16: c = t_cnt'(15);
            default:  c = t_cnt'(WORD_W - 1);
        endcase
        return c;
    endfunction

    function automatic int field_bits(int s);
        return (s == 0) ? 8 : ((s == 1) ? 16 : WORD_W);
    endfunction

    function automatic t_poly field_poly(int s);
        return (s == 0) ? POLY_GF8 : ((s == 1) ? POLY_GF16 : POLY_GF32);
    endfunction

    // Build the fold table by repeated multiplication by x
    function automatic t_red_tab build_red_tab();
        t_red_tab tab;
        t_poly    v;
        int       m;
        tab = '0;
        for (int s = 0; s < NUM_FIELDS; s++) begin
            m = field_bits(s);
            v = t_poly'(1);
            for (int k = 0; k < PROD_W; k++) begin
                tab[s][k] = v[WORD_W-1:0];
                v = v << 1;
                if (v[m]) begin
                    v = v ^ field_poly(s);
                end
            end
        end
        return tab;
    endfunction

    localparam t_red_tab RED_TAB = build_red_tab();

endpackage

### hw/rtl/binary_field_arithmetic_unit.sv
// Add, subtract, negate and multiply pass through the operand registers, the accumulator and
// the output register. Inverse and divide run a square-and-multiply ladder over the m field bits
// (m = 8, 16 or 32), one squaring or one multiplication per cycle in the single shared field multiplier.
// Throughput: one item in flight; the next item is taken once the result is in the output
// register, which holds it until the consumer takes it. Reset (synchronous, active low)
// empties the output and selects GF(2^8).
`include "assert_macros.svh"

module binary_field_arithmetic_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_value,
    output logic        o_error_flag
);

    gfa_pkg::t_cmd  cmd;
    gfa_pkg::t_stat stat;

    gfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    gfa_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req_type),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result_value (o_result_value),
        .o_error_flag   (o_error_flag)
    );

    // Checks
    `ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_valid && o_error_flag, o_result_value == '0)
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `ASSERT_IMPL(a_gf8_width, i_clk, i_rst_n,
                 o_valid && (stat.sel == gfa_pkg::SEL_GF8), o_result_value[31:8] == '0)
    `ASSERT_IMPL(a_load_free, i_clk, i_rst_n, cmd.out_load, !o_valid || !i_stall)

endmodule

### hw/rtl/gfa_datapath.sv
module gfa_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  gfa_pkg::t_sel       i_cfg_data,
    input  gfa_pkg::t_op        i_req_type,
    input  gfa_pkg::t_word      i_operand_a,
    input  gfa_pkg::t_word      i_operand_b,
    input  gfa_pkg::t_cmd       i_cmd,
    output gfa_pkg::t_stat      o_stat,
    output gfa_pkg::t_word      o_result_value,
    output logic                o_error_flag
);

    gfa_pkg::t_sel  r_field_sel;
    gfa_pkg::t_op   r_op;
    gfa_pkg::t_word r_a;
    gfa_pkg::t_word r_b;
    gfa_pkg::t_word r_acc;
    logic           r_err;
    gfa_pkg::t_word r_res;
    logic           r_res_err;

    gfa_pkg::t_word n_acc;
    gfa_pkg::t_word mask;
    gfa_pkg::t_sel  sel_sat;
    logic [gfa_pkg::CNT_W:0] m_bits;
    gfa_pkg::t_word mul_a;
    gfa_pkg::t_word mul_b;
    gfa_pkg::t_prod prod;
    gfa_pkg::t_word mul_res;

    assign sel_sat = gfa_pkg::sat_sel(r_field_sel);
    assign mask    = gfa_pkg::field_mask(r_field_sel);
    assign m_bits  = {1'b0, gfa_pkg::field_m1(r_field_sel)} + 1'b1;

    // Hold the field selector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_sel <= gfa_pkg::SEL_GF8;
        end else if (i_cfg_we) begin
            r_field_sel <= i_cfg_data;
        end
    end

    // Select multiplier operands
    always_comb begin
        unique case (i_cmd.mul_sel)
            gfa_pkg::MUL_AB: begin mul_a = r_a;   mul_b = r_b;   end
            gfa_pkg::MUL_SQ: begin mul_a = r_acc; mul_b = r_acc; end
            gfa_pkg::MUL_AX: begin mul_a = r_acc; mul_b = r_a;   end
            default:         begin mul_a = r_acc; mul_b = r_b;   end
        endcase
    end

    // Carry-less product: XOR of shifted partial products
    always_comb begin
        prod = '0;
        for (int i = 0; i < gfa_pkg::WORD_W; i++) begin
            if (mul_b[i]) begin
                prod = prod ^ (gfa_pkg::t_prod'(mul_a) << i);
            end
        end
    end

    // Fold every bit at or above the field width back in through the table
    always_comb begin
        mul_res = prod[gfa_pkg::WORD_W-1:0] & mask;
        for (int k = 0; k < gfa_pkg::PROD_W; k++) begin
            if (((gfa_pkg::CNT_W+1)'(k) >= m_bits) && prod[k]) begin
                mul_res = mul_res ^ gfa_pkg::RED_TAB[sel_sat][k];
            end
        end
    end

    // Pick the next accumulator value
    always_comb begin
        unique case (i_cmd.acc_sel)
            gfa_pkg::ACC_MUL:  n_acc = mul_res;
            gfa_pkg::ACC_XOR:  n_acc = r_a ^ r_b;
            gfa_pkg::ACC_A:    n_acc = r_a;
            gfa_pkg::ACC_ZERO: n_acc = '0;
            gfa_pkg::ACC_ONE:  n_acc = gfa_pkg::t_word'(1);
            default:           n_acc = r_acc;
        endcase
    end

    // Capture masked operands, update accumulator, load output
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_req_type;
            r_a  <= i_operand_a & mask;
            r_b  <= i_operand_b & mask;
        end
        r_acc <= n_acc;
        if (i_cmd.err_load) begin
            r_err <= i_cmd.err_val;
        end
        if (i_cmd.out_load) begin
            r_res     <= r_acc;
            r_res_err <= r_err;
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.a_zero   = (r_a == '0);
    assign o_stat.b_zero   = (r_b == '0);
    assign o_stat.m_minus1 = gfa_pkg::field_m1(r_field_sel);
    assign o_stat.sel      = r_field_sel;

    assign o_result_value = r_res;
    assign o_error_flag   = r_res_err;

endmodule

### hw/rtl/gfa_ctrl.sv
module gfa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  gfa_pkg::t_stat  i_stat,
    output gfa_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SQR  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIVM = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    gfa_pkg::t_cnt r_cnt;
    gfa_pkg::t_cnt n_cnt;
    logic          r_out_valid;
    logic          n_out_valid;
    gfa_pkg::t_cmd cmd;
    logic          in_take;
    logic          out_take;

    assign o_stall  = (r_state != S_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;

    // Sequence one item through the datapath and its shared multiplier
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        cmd.acc_sel = gfa_pkg::ACC_HOLD;
        cmd.mul_sel = gfa_pkg::MUL_AB;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    cmd.capture = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.err_load = 1'b1;
                n_state      = S_DONE;
                unique case (i_stat.op)
                    gfa_pkg::OP_ADD, gfa_pkg::OP_SUB: cmd.acc_sel = gfa_pkg::ACC_XOR;
                    gfa_pkg::OP_MUL: cmd.acc_sel = gfa_pkg::ACC_MUL;
                    gfa_pkg::OP_NEG: cmd.acc_sel = gfa_pkg::ACC_A;
                    gfa_pkg::OP_INV, gfa_pkg::OP_DIV: begin
                        if ((i_stat.op == gfa_pkg::OP_INV) ? i_stat.a_zero
                                                           : i_stat.b_zero) begin
                            cmd.acc_sel = gfa_pkg::ACC_ZERO;
                            cmd.err_val = 1'b1;
                        end else begin
                            // start the power ladder from one
                            cmd.acc_sel = gfa_pkg::ACC_ONE;
                            n_cnt       = i_stat.m_minus1;
                            n_state     = S_SQR;
                        end
                    end
                    default: cmd.acc_sel = gfa_pkg::ACC_ZERO;
                endcase
            end
            S_SQR: begin
                cmd.mul_sel = gfa_pkg::MUL_SQ;
                cmd.acc_sel = gfa_pkg::ACC_MUL;
                if (r_cnt == '0) begin
                    n_state = (i_stat.op == gfa_pkg::OP_DIV) ? S_DIVM : S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // every exponent bit but the lowest is set
                cmd.mul_sel = (i_stat.op == gfa_pkg::OP_DIV) ? gfa_pkg::MUL_BX
                                                             : gfa_pkg::MUL_AX;
                cmd.acc_sel = gfa_pkg::ACC_MUL;
                n_cnt       = r_cnt - 1'b1;
                n_state     = S_SQR;
            end
            S_DIVM: begin
                cmd.mul_sel = gfa_pkg::MUL_AX;
                cmd.acc_sel = gfa_pkg::ACC_MUL;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Track the output register
    always_comb begin
        priority if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd   = cmd;
    assign o_valid = r_out_valid;

endmodule
